// ===== rtl/core/cfr_pkg.sv =====
`timescale 1ns / 1ps
package cfr_pkg;

    // frame markers, kinds and crc constants
    localparam logic [7:0]  MARK_START = 8'hAA;
    localparam logic [7:0]  MARK_END   = 8'hBB;
    localparam logic [7:0]  KIND_FFT   = 8'h01;
    localparam logic [7:0]  KIND_CMD   = 8'h02;
    localparam logic [7:0]  KIND_AUX   = 8'h03;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_MSB    = 16'h8000;
    localparam int          MAX_CHUNKS = 9;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_HDR = 3'd1;
    localparam logic [2:0] ST_BAD_END = 3'd2;
    localparam logic [2:0] ST_BAD_CRC = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    // input kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register indexes
    localparam logic [1:0] CFG_MAIN_LEN = 2'd0;
    localparam logic [1:0] CFG_AUX_LEN  = 2'd1;
    localparam logic [1:0] CFG_IDLE_LIM = 2'd2;

    // datapath commands
    localparam logic [3:0] DP_NONE      = 4'd0;
    localparam logic [3:0] DP_ACCEPT    = 4'd1;
    localparam logic [3:0] DP_EMIT_IDLE = 4'd2;
    localparam logic [3:0] DP_END_RD    = 4'd3;
    localparam logic [3:0] DP_CRC_INIT  = 4'd4;
    localparam logic [3:0] DP_CRC       = 4'd5;
    localparam logic [3:0] DP_CRC_LO    = 4'd6;
    localparam logic [3:0] DP_CHK_INIT  = 4'd7;
    localparam logic [3:0] DP_CHK       = 4'd8;
    localparam logic [3:0] DP_CHK_EMIT  = 4'd9;
    localparam logic [3:0] DP_EMPTY     = 4'd10;
    localparam logic [3:0] DP_EMIT_ERR  = 4'd11;
    localparam logic [3:0] DP_RS_INIT   = 4'd12;
    localparam logic [3:0] DP_SCAN      = 4'd13;
    localparam logic [3:0] DP_COPY      = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] err_code;
    } cmd_t;

    typedef struct packed {
        logic tick_drop;
        logic to_hdr;
        logic hdr_bad;
        logic frame_done;
        logic end_ok;
        logic crc_last;
        logic crc_ok;
        logic plen_zero;
        logic chk_full;
        logic chk_last;
        logic rs_none;
        logic scan_found;
        logic scan_end;
        logic copy_end;
        logic out_free;
    } stat_t;

    // one byte of crc-16, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) c = {c[14:0], 1'b0} ^ CRC_POLY;
            else c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+------------------------------------------
// s_ input  | in  | s_tvalid/s_tready  | s_tdata rx_byte, s_tuser op
// m_ result | out | m_tvalid/m_tready  | m_tdata header bytes, chunk, count; m_tuser
//           |     |                    | status; m_tlast last
// cfg       | in  | cfg_we             | cfg_index, cfg_wdata
//
// a tick that drops the frame goes on to emit an idle result; a byte that does not
// complete a frame goes through a header check once the header is held
// for a complete good frame, the crc walk and chunk reads go through the one read
// port of the frame store, one byte a cycle; a chunk emit waits while output stalls
// after an error result, a resync scans for a start byte and moves the rest down
// input is taken only between items; results wait in one output register under stall
// synchronous active-low reset clears control state; the store needs no clearing
module crc_checked_frame_receiver import cfr_pkg::*; #(
    parameter int STORE_BYTES = 80,
    parameter int CHUNK_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [7:0] frame_type, [15:8] sequence_res,
                                   // [23:16] payload_length, [87:24] chunk,
                                   // [91:88] chunk_bytes, [95:92] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    cmd_t  cmd;
    stat_t st;
    logic [7:0]  o_type, o_seq, o_len;
    logic [63:0] o_chunk;
    logic [3:0]  o_bytes;

    cfr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .st(st), .cmd(cmd)
    );

    cfr_dp #(.STORE_BYTES(STORE_BYTES), .CHUNK_BYTES(CHUNK_BYTES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st),
        .in_op(s_tuser), .in_byte(s_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_status(m_tuser),
        .out_type(o_type), .out_seq(o_seq), .out_len(o_len), .out_chunk(o_chunk),
        .out_bytes(o_bytes), .out_last(m_tlast)
    );

    // result word packing
    assign m_tdata = {4'b0000, o_bytes, o_chunk, o_len, o_seq, o_type};
endmodule

// ===== rtl/core/cfr_ram.sv =====
`timescale 1ns / 1ps
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/cfr_ctrl.sv =====
`timescale 1ns / 1ps
module cfr_ctrl import cfr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t st,
    output cmd_t  cmd
);
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_EMIT_IDLE = 5'd1;
    localparam logic [4:0] S_HDR       = 5'd2;
    localparam logic [4:0] S_END_RD    = 5'd3;
    localparam logic [4:0] S_END_CHK   = 5'd4;
    localparam logic [4:0] S_CRC_INIT  = 5'd5;
    localparam logic [4:0] S_CRC       = 5'd6;
    localparam logic [4:0] S_CRC_LO    = 5'd7;
    localparam logic [4:0] S_CRC_HI    = 5'd8;
    localparam logic [4:0] S_CHK_INIT  = 5'd9;
    localparam logic [4:0] S_CHK       = 5'd10;
    localparam logic [4:0] S_CHK_EMIT  = 5'd11;
    localparam logic [4:0] S_EMPTY     = 5'd12;
    localparam logic [4:0] S_EMIT_ERR  = 5'd13;
    localparam logic [4:0] S_RS_INIT   = 5'd14;
    localparam logic [4:0] S_SCAN      = 5'd15;
    localparam logic [4:0] S_COPY      = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [2:0] err_reg, err_next;

    assign s_tready = (state_reg == S_IDLE);

    // sequencing
    always_comb begin
        state_next   = state_reg;
        err_next     = err_reg;
        cmd.op       = DP_NONE;
        cmd.err_code = err_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op = DP_ACCEPT;
                    if (st.tick_drop) state_next = S_EMIT_IDLE;
                    else if (st.to_hdr) state_next = S_HDR;
                end
            end
            S_EMIT_IDLE: begin
                if (st.out_free) begin
                    cmd.op = DP_EMIT_IDLE;
                    state_next = S_IDLE;
                end
            end
            S_HDR: begin
                if (st.hdr_bad) begin
                    err_next = ST_BAD_HDR;
                    state_next = S_EMIT_ERR;
                end else if (st.frame_done) state_next = S_END_RD;
                else state_next = S_IDLE;
            end
            S_END_RD: begin
                cmd.op = DP_END_RD;
                state_next = S_END_CHK;
            end
            S_END_CHK: begin
                if (st.end_ok) state_next = S_CRC_INIT;
                else begin
                    err_next = ST_BAD_END;
                    state_next = S_EMIT_ERR;
                end
            end
            S_CRC_INIT: begin
                cmd.op = DP_CRC_INIT;
                state_next = S_CRC;
            end
            S_CRC: begin
                cmd.op = DP_CRC;
                if (st.crc_last) state_next = S_CRC_LO;
            end
            S_CRC_LO: begin
                cmd.op = DP_CRC_LO;
                state_next = S_CRC_HI;
            end
            S_CRC_HI: begin
                if (!st.crc_ok) begin
                    err_next = ST_BAD_CRC;
                    state_next = S_EMIT_ERR;
                end else if (st.plen_zero) state_next = S_EMPTY;
                else state_next = S_CHK_INIT;
            end
            S_CHK_INIT: begin
                cmd.op = DP_CHK_INIT;
                state_next = S_CHK;
            end
            S_CHK: begin
                cmd.op = DP_CHK;
                if (st.chk_full) state_next = S_CHK_EMIT;
            end
            S_CHK_EMIT: begin
                if (st.out_free) begin
                    cmd.op = DP_CHK_EMIT;
                    state_next = st.chk_last ? S_IDLE : S_CHK;
                end
            end
            S_EMPTY: begin
                if (st.out_free) begin
                    cmd.op = DP_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_ERR: begin
                if (st.out_free) begin
                    cmd.op = DP_EMIT_ERR;
                    state_next = S_RS_INIT;
                end
            end
            S_RS_INIT: begin
                cmd.op = DP_RS_INIT;
                state_next = st.rs_none ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                cmd.op = DP_SCAN;
                if (st.scan_found) state_next = S_COPY;
                else if (st.scan_end) state_next = S_IDLE;
            end
            S_COPY: begin
                cmd.op = DP_COPY;
                if (st.copy_end) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            err_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end
endmodule

// ===== rtl/core/cfr_dp.sv =====
`timescale 1ns / 1ps
module cfr_dp import cfr_pkg::*; #(
    parameter int STORE_BYTES = 80,
    parameter int CHUNK_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic        in_op,
    input  logic [7:0]  in_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_status,
    output logic [7:0]  out_type,
    output logic [7:0]  out_seq,
    output logic [7:0]  out_len,
    output logic [63:0] out_chunk,
    output logic [3:0]  out_bytes,
    output logic        out_last
);
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int CNT_W  = $clog2(STORE_BYTES + 1);
    localparam logic [8:0] STORE_N   = 9'(STORE_BYTES);
    localparam logic [7:0] MAX_PLEN  = 8'(MAX_CHUNKS * CHUNK_BYTES);
    localparam logic [3:0] CHUNK_N   = 4'(CHUNK_BYTES);

    // configuration
    logic [6:0] main_len_reg, aux_len_reg;
    logic [7:0] idle_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_len_reg <= 7'd68;
            aux_len_reg  <= 7'd36;
            idle_lim_reg <= 8'd10;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAIN_LEN: main_len_reg <= cfg_wdata[6:0];
                CFG_AUX_LEN:  aux_len_reg  <= cfg_wdata[6:0];
                CFG_IDLE_LIM: idle_lim_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0]  fill_reg, ptr_reg;
    logic [ADDR_W-1:0] dst_reg;
    logic [7:0]        idle_reg, hdr_type_reg, hdr_seq_reg, hdr_len_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        crc_lo_reg, rem_reg;
    logic [3:0]        cnt_reg;
    logic [63:0]       chunk_reg;
    logic              ov_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, rdata;

    cfr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(rdata)
    );

    // derived values
    logic [8:0]       need, fill9, ptr9;
    logic [CNT_W-1:0] ptr_p1;
    logic [7:0]       idle_inc;
    logic             len_ok;

    assign need     = 9'(hdr_len_reg) + 9'd7;
    assign fill9    = 9'(fill_reg);
    assign ptr9     = 9'(ptr_reg);
    assign ptr_p1   = ptr_reg + 1'b1;
    assign idle_inc = (idle_reg == 8'hFF) ? idle_reg : idle_reg + 8'd1;

    always_comb begin
        if (hdr_type_reg == KIND_FFT || hdr_type_reg == KIND_CMD)
            len_ok = (hdr_len_reg == {1'b0, main_len_reg});
        else if (hdr_type_reg == KIND_AUX)
            len_ok = (hdr_len_reg == {1'b0, aux_len_reg});
        else
            len_ok = 1'b0;
    end

    // status to controller
    always_comb begin
        st.tick_drop  = in_op == OP_TICK && fill_reg != '0 && idle_inc >= idle_lim_reg;
        st.to_hdr     = in_op == OP_BYTE && fill9 >= 9'd3 && fill9 < STORE_N;
        st.hdr_bad    = !len_ok || need > STORE_N || hdr_len_reg > MAX_PLEN;
        st.frame_done = fill9 >= need;
        st.end_ok     = rdata == MARK_END;
        st.crc_last   = ptr9 == 9'(hdr_len_reg) + 9'd3;
        st.crc_ok     = {rdata, crc_lo_reg} == crc_reg;
        st.plen_zero  = hdr_len_reg == 8'd0;
        st.chk_full   = (cnt_reg + 4'd1 == CHUNK_N) || (rem_reg == 8'd1);
        st.chk_last   = rem_reg == 8'd0;
        st.rs_none    = fill9 <= 9'd1;
        st.scan_found = rdata == MARK_START;
        st.scan_end   = 9'(ptr_p1) >= fill9;
        st.copy_end   = ptr_p1 == fill_reg;
        st.out_free   = !ov_reg || out_ready;
    end

    // store ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = fill_reg[ADDR_W-1:0];
        ram_wdata = in_byte;
        if (cmd.op == DP_ACCEPT && in_op == OP_BYTE) begin
            if (fill_reg == '0) begin
                ram_we    = in_byte == MARK_START;
                ram_waddr = '0;
            end else begin
                ram_we    = fill9 < STORE_N;
            end
        end else if (cmd.op == DP_COPY) begin
            ram_we    = 1'b1;
            ram_waddr = dst_reg;
            ram_wdata = rdata;
        end
        unique case (cmd.op)
            DP_END_RD:   ram_raddr = ADDR_W'(need - 9'd1);
            DP_CRC_INIT: ram_raddr = ADDR_W'(1);
            DP_RS_INIT:  ram_raddr = ADDR_W'(1);
            DP_CHK_INIT: ram_raddr = ADDR_W'(4);
            DP_CHK_EMIT: ram_raddr = ptr_reg[ADDR_W-1:0];
            DP_SCAN:     ram_raddr = st.scan_found ? ptr_reg[ADDR_W-1:0]
                                                   : ptr_p1[ADDR_W-1:0];
            default:     ram_raddr = ptr_p1[ADDR_W-1:0];
        endcase
    end

    // result fields, header bytes masked by fill
    logic       emit;
    logic [2:0] emit_status;
    logic [63:0] emit_chunk;
    logic [3:0] emit_bytes;
    logic       emit_last;

    always_comb begin
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_chunk  = '0;
        emit_bytes  = '0;
        emit_last   = 1'b1;
        unique case (cmd.op)
            DP_EMIT_IDLE: begin
                emit = 1'b1;
                emit_status = ST_IDLE;
            end
            DP_EMIT_ERR: begin
                emit = 1'b1;
                emit_status = cmd.err_code;
            end
            DP_EMPTY: emit = 1'b1;
            DP_CHK_EMIT: begin
                emit       = 1'b1;
                emit_chunk = chunk_reg;
                emit_bytes = cnt_reg;
                emit_last  = rem_reg == 8'd0;
            end
            default: ;
        endcase
    end

    // control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            idle_reg <= '0;
            ov_reg   <= 1'b0;
        end else begin
            if (emit) ov_reg <= 1'b1;
            else if (ov_reg && out_ready) ov_reg <= 1'b0;
            unique case (cmd.op)
                DP_ACCEPT: begin
                    if (in_op == OP_TICK) begin
                        if (fill_reg != '0) idle_reg <= idle_inc;
                    end else begin
                        idle_reg <= '0;
                        if (fill_reg == '0) begin
                            if (in_byte == MARK_START) fill_reg <= CNT_W'(1);
                        end else if (fill9 >= STORE_N) fill_reg <= '0;
                        else fill_reg <= fill_reg + 1'b1;
                    end
                end
                DP_EMIT_IDLE: begin
                    fill_reg <= '0;
                    idle_reg <= '0;
                end
                DP_EMPTY: fill_reg <= '0;
                DP_CHK_EMIT: if (rem_reg == 8'd0) fill_reg <= '0;
                DP_RS_INIT:  if (st.rs_none) fill_reg <= '0;
                DP_SCAN:     if (!st.scan_found && st.scan_end) fill_reg <= '0;
                DP_COPY:     if (st.copy_end) fill_reg <= CNT_W'(dst_reg) + 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_status <= emit_status;
            out_type   <= (fill9 > 9'd1) ? hdr_type_reg : 8'd0;
            out_seq    <= (fill9 > 9'd2) ? hdr_seq_reg : 8'd0;
            out_len    <= (fill9 > 9'd3) ? hdr_len_reg : 8'd0;
            out_chunk  <= emit_chunk;
            out_bytes  <= emit_bytes;
            out_last   <= emit_last;
        end
        // header copies of store positions one to three
        if (ram_we) begin
            if (ram_waddr == ADDR_W'(1)) hdr_type_reg <= ram_wdata;
            if (ram_waddr == ADDR_W'(2)) hdr_seq_reg  <= ram_wdata;
            if (ram_waddr == ADDR_W'(3)) hdr_len_reg  <= ram_wdata;
        end
        unique case (cmd.op)
            DP_CRC_INIT: begin
                crc_reg <= CRC_INIT;
                ptr_reg <= CNT_W'(1);
            end
            DP_CRC: begin
                crc_reg <= crc_byte(crc_reg, rdata);
                ptr_reg <= ptr_p1;
            end
            DP_CRC_LO: begin
                crc_lo_reg <= rdata;
                ptr_reg    <= ptr_p1;
            end
            DP_CHK_INIT: begin
                ptr_reg   <= CNT_W'(4);
                cnt_reg   <= '0;
                rem_reg   <= hdr_len_reg;
                chunk_reg <= '0;
            end
            DP_CHK: begin
                chunk_reg[{cnt_reg[2:0], 3'b000} +: 8] <= rdata;
                cnt_reg <= cnt_reg + 4'd1;
                rem_reg <= rem_reg - 8'd1;
                ptr_reg <= ptr_p1;
            end
            DP_CHK_EMIT: begin
                cnt_reg   <= '0;
                chunk_reg <= '0;
            end
            DP_RS_INIT: ptr_reg <= CNT_W'(1);
            DP_SCAN: begin
                if (st.scan_found) dst_reg <= '0;
                else ptr_reg <= ptr_p1;
            end
            DP_COPY: begin
                ptr_reg <= ptr_p1;
                dst_reg <= dst_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid = ov_reg;
endmodule
